// ===== hdl/apm_pkg.sv =====
// ----------------------------------------------------------------------------
// apm_pkg: shared definitions for the approximate pattern matcher
// Item kind codes, letter bounds, register addresses and fixed field widths.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int KIND_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int PIDX_W   = 5;
  localparam int PLEN_W   = 6;
  localparam int KERR_W   = 2;
  localparam int START_W  = 32;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_CLEAR = 2'd0;
  localparam kind_t KIND_LOAD  = 2'd1;
  localparam kind_t KIND_TEXT  = 2'd2;

  localparam logic [SYMBOL_W-1:0] LETTER_FIRST = 8'h61;  // 'a'
  localparam logic [SYMBOL_W-1:0] LETTER_LAST  = 8'h7a;  // 'z'

  // register select taken from bit 2 of the byte address
  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_MAX_MISMATCHES = 1'b1;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 6'd1;
  localparam logic [KERR_W-1:0] KERR_RESET = 2'd0;

endpackage

// ===== hdl/approx_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// approx_pattern_matcher
// Shift-And matcher with up to k substituted characters. Letter masks sit in
// a synchronous RAM; the k+1 match vectors and text position are registers.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | tuser: kind; tdata: symbol, pattern_index
//  out_    | out | tdata: found, start_position (one beat per text beat)
//  cfg_    | in  | APB: 0x0 pattern_length, 0x4 max_mismatches
//
// One beat per cycle sustained. The mask RAM is read at acceptance into
// stage 1, where the beat is resolved; a text result lands in the output
// register when it leaves stage 1. A write followed at once by a read of
// the same letter is forwarded. Reset (and a clear beat) empties the mask
// table at once through per-letter valid bits; no clearing pass. The input
// stalls only while a text result waits on a full, stalled output register.
module approx_pattern_matcher
  import apm_pkg::*;
#(
  parameter int PATTERN_MAX    = 32,
  parameter int ERRORS_MAX     = 3,
  parameter int ALPHABET_SIZE  = 26,
  parameter int POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] symbol, [12:8] pattern_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] found, [32:1] start_position, rest zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SLOT_W = $clog2(ALPHABET_SIZE);
  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int KW     = (ERRORS_MAX > 0) ? $clog2(ERRORS_MAX + 1) : 1;
  localparam int NVEC   = ERRORS_MAX + 1;

  typedef logic [PATTERN_MAX-1:0] vec_t;

  // configuration
  logic [PLEN_W-1:0] plen_r;
  logic [KERR_W-1:0] kerr_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= PLEN_RESET;
      kerr_r <= KERR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_PATTERN_LENGTH: plen_r <= cfg_pwdata[PLEN_W-1:0];
        REG_MAX_MISMATCHES: kerr_r <= cfg_pwdata[KERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PATTERN_LENGTH: cfg_prdata = {{(32-PLEN_W){1'b0}}, plen_r};
      REG_MAX_MISMATCHES: cfg_prdata = {{(32-KERR_W){1'b0}}, kerr_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // input decode
  logic                in_acc;
  kind_t               in_kind;
  logic [SYMBOL_W-1:0] in_sym;
  logic [PIDX_W-1:0]   in_pidx;
  logic [8:0]          in_off;
  logic                in_letter;
  logic [SLOT_W-1:0]   in_slot;

  assign in_acc  = in_tvalid & in_tready;
  assign in_kind = in_tuser[KIND_W-1:0];
  assign in_sym  = in_tdata[SYMBOL_W-1:0];
  assign in_pidx = in_tdata[SYMBOL_W +: PIDX_W];
  assign in_off  = {1'b0, in_sym} - {1'b0, LETTER_FIRST};
  assign in_letter = (in_sym >= LETTER_FIRST) && (in_sym <= LETTER_LAST)
                     && (in_off < 9'(ALPHABET_SIZE));
  assign in_slot = in_letter ? in_off[SLOT_W-1:0] : '0;

  // stage 1: beat waiting on its mask read
  logic              s1_vld_r;
  kind_t             s1_kind_r;
  logic              s1_letter_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [PIDX_W-1:0] s1_pidx_r;
  logic              s1_go;
  logic              out_free;

  // output register
  logic              out_vld_r;
  logic              out_found_r;
  logic [START_W-1:0] out_start_r;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_go     = s1_vld_r && ((s1_kind_r != KIND_TEXT) || out_free);
  assign in_tready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= in_kind;
      s1_letter_r <= in_letter;
      s1_slot_r   <= in_slot;
      s1_pidx_r   <= in_pidx;
    end
  end

  // mask RAM with per-letter valid bits and write forwarding
  vec_t                     mask_mem [ALPHABET_SIZE];
  vec_t                     rd_data_r;
  logic [ALPHABET_SIZE-1:0] mvalid_r;
  logic                     fwd_vld_r;
  logic [SLOT_W-1:0]        fwd_slot_r;
  vec_t                     fwd_data_r;
  vec_t                     cur_mask;
  vec_t                     set_bit;
  vec_t                     new_mask;
  logic                     pidx_ok;
  logic                     do_load;
  logic                     do_clear;
  logic                     do_text;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mask_mem[in_slot];
    end
  end

  always_comb begin
    if (!mvalid_r[s1_slot_r] || !s1_letter_r) begin
      cur_mask = '0;
    end else if (fwd_vld_r && (fwd_slot_r == s1_slot_r)) begin
      cur_mask = fwd_data_r;
    end else begin
      cur_mask = rd_data_r;
    end
  end

  assign pidx_ok  = 7'(s1_pidx_r) < 7'(PATTERN_MAX);
  assign set_bit  = vec_t'(1) << s1_pidx_r;
  assign new_mask = cur_mask | set_bit;
  assign do_load  = s1_go && (s1_kind_r == KIND_LOAD) && s1_letter_r && pidx_ok;
  assign do_clear = s1_go && (s1_kind_r == KIND_CLEAR);
  assign do_text  = s1_go && (s1_kind_r == KIND_TEXT);

  always_ff @(posedge clk) begin
    if (do_load) begin
      mask_mem[s1_slot_r] <= new_mask;
      fwd_slot_r          <= s1_slot_r;
      fwd_data_r          <= new_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      mvalid_r  <= '0;
      fwd_vld_r <= 1'b0;
    end else if (do_load) begin
      mvalid_r[s1_slot_r] <= 1'b1;
      fwd_vld_r           <= 1'b1;
    end
  end

  // match vectors and text position
  vec_t                      vec_r   [NVEC];
  vec_t                      vec_nxt [NVEC];
  logic [POSITION_WIDTH-1:0] pos_r;
  logic [6:0]                m_eff;
  logic [6:0]                mm1;
  logic [4:0]                k_eff;
  logic                      hit;
  logic [POSITION_WIDTH-1:0] start_full;
  logic [START_W-1:0]        start_cut;

  always_comb begin
    for (int j = 0; j < NVEC; j++) begin
      vec_nxt[j] = ((vec_r[j] << 1) | vec_t'(1)) & cur_mask;
      if (j > 0) begin
        vec_nxt[j] = vec_nxt[j] | (vec_r[j-1] << 1) | vec_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      for (int j = 0; j < NVEC; j++) begin
        vec_r[j] <= '0;
      end
      pos_r <= '0;
    end else if (do_text) begin
      for (int j = 0; j < NVEC; j++) begin
        vec_r[j] <= vec_nxt[j];
      end
      pos_r <= pos_r + 1'b1;
    end
  end

  // clamp m to 1..PATTERN_MAX and k to ERRORS_MAX
  always_comb begin
    priority if (plen_r == '0) begin
      m_eff = 7'd1;
    end else if (7'(plen_r) > 7'(PATTERN_MAX)) begin
      m_eff = 7'(PATTERN_MAX);
    end else begin
      m_eff = 7'(plen_r);
    end
    k_eff = (5'(kerr_r) > 5'(ERRORS_MAX)) ? 5'(ERRORS_MAX) : 5'(kerr_r);
  end

  assign mm1        = m_eff - 7'd1;
  assign hit        = vec_nxt[k_eff[KW-1:0]][mm1[IDX_W-1:0]];
  assign start_full = pos_r - POSITION_WIDTH'(mm1);

  generate
    if (POSITION_WIDTH >= START_W) begin : g_start_trunc
      assign start_cut = start_full[START_W-1:0];
    end else begin : g_start_ext
      assign start_cut = {{(START_W-POSITION_WIDTH){1'b0}}, start_full};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (do_text) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_text) begin
      out_found_r <= hit;
      out_start_r <= hit ? start_cut : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_start_r, out_found_r};

  // checks
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (mvalid_r == '0) && (pos_r == '0))
    else $error("clear beat did not empty mask table and position");

  a_text_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_text |=> out_vld_r)
    else $error("text beat produced no result");

  a_stall_only_on_text: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r && (s1_kind_r == KIND_TEXT) && out_vld_r && !out_tready)
    else $error("input stalled without a blocked text result");

  a_miss_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_found_r |-> (out_start_r == '0))
    else $error("start position nonzero on a miss");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    do_text |=> (pos_r == $past(pos_r) + 1'b1))
    else $error("text position did not advance");

endmodule

// ===== tb/match_checker.sv =====
// ----------------------------------------------------------------------------
// match_checker: scoreboard for the approximate pattern matcher
// Snoops the input, result and register channels, predicts every text result
// with a bit-parallel Shift-And model of its own and compares field by field.
// ----------------------------------------------------------------------------
module match_checker
  import apm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] symbol, [12:8] pattern_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [0] found, [32:1] start_position, rest zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          results_pending
);

  localparam int NUM_LETTERS = 26;
  localparam int NUM_VECTORS = 4;
  localparam int VEC_W       = 32;
  localparam int PATTERN_MAX = 32;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
  } match_result_t;

  logic [VEC_W-1:0]   letter_mask [NUM_LETTERS];
  logic [VEC_W-1:0]   match_vec [NUM_VECTORS];
  logic [START_W-1:0] text_pos;
  logic [PLEN_W-1:0]  plen_reg;
  logic [KERR_W-1:0]  kerr_reg;
  match_result_t      expected_hits[$];
  int                 mismatches = 0;
  int                 queued = 0;

  assign mismatch_count  = mismatches;
  assign results_pending = queued;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function automatic bit is_letter(input logic [SYMBOL_W-1:0] sym);
    return sym >= LETTER_FIRST && sym <= LETTER_LAST;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < NUM_LETTERS; i++) letter_mask[i] = '0;
    for (int j = 0; j < NUM_VECTORS; j++) match_vec[j] = '0;
    text_pos = '0;
  endtask

  task automatic shift_and_step(input kind_t kind, input logic [SYMBOL_W-1:0] sym,
                                input logic [PIDX_W-1:0] pidx);
    logic [VEC_W-1:0] sym_mask;
    logic [VEC_W-1:0] prev;
    logic [VEC_W-1:0] old;
    logic [VEC_W-1:0] cur;
    int               m;
    match_result_t    res;
    case (kind)
      KIND_CLEAR: clear_tables();
      KIND_LOAD: begin
        if (is_letter(sym)) letter_mask[sym - LETTER_FIRST][pidx] = 1'b1;
      end
      KIND_TEXT: begin
        m = (plen_reg == 0) ? 1 : ((plen_reg > PATTERN_MAX) ? PATTERN_MAX : int'(plen_reg));
        sym_mask = is_letter(sym) ? letter_mask[sym - LETTER_FIRST] : '0;
        // every vector advances from the old values of its neighbor
        prev = '0;
        for (int j = 0; j < NUM_VECTORS; j++) begin
          old = match_vec[j];
          cur = ((old << 1) | VEC_W'(1)) & sym_mask;
          if (j > 0) cur |= (prev << 1) | VEC_W'(1);
          match_vec[j] = cur;
          prev = old;
        end
        res.found = match_vec[kerr_reg][m-1];
        res.start = res.found ? text_pos - START_W'(m - 1) : '0;
        text_pos++;
        expected_hits.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    match_result_t    want;
    logic [31:0]      reg_value;
    if (!rst_n) begin
      clear_tables();
      plen_reg = PLEN_RESET;
      kerr_reg = KERR_RESET;
      expected_hits.delete();
    end else begin
      // predict first so that a same-edge result still finds its entry
      if (in_tvalid && in_tready)
        shift_and_step(kind_t'(in_tuser), in_tdata[7:0], in_tdata[12:8]);
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_tdata[31:0], '0);
        end else begin
          want = expected_hits.pop_front();
          if (out_tdata[0] !== want.found)
            report_mismatch("found", 32'(out_tdata[0]), 32'(want.found));
          if (out_tdata[32:1] !== want.start)
            report_mismatch("start_position", out_tdata[32:1], want.start);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_PATTERN_LENGTH) plen_reg = cfg_pwdata[PLEN_W-1:0];
          else kerr_reg = cfg_pwdata[KERR_W-1:0];
        end else begin
          reg_value = (cfg_paddr[2] == REG_PATTERN_LENGTH) ? 32'(plen_reg) : 32'(kerr_reg);
          if (cfg_prdata !== reg_value)
            report_mismatch("register read", cfg_prdata, reg_value);
        end
      end
    end
    queued <= expected_hits.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the approximate pattern matcher
// Drives directed and random pattern/text streams with random idle and stall
// bursts across many register settings; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;
  import apm_pkg::*;

  localparam int    ITEM_TARGET   = 1470;
  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    SETTLE_CYCLES = 4;
  localparam kind_t KIND_UNUSED   = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  logic [SYMBOL_W-1:0] pattern [32];

  approx_pattern_matcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  match_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (fail_count),
    .results_pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input kind_t kind, input logic [SYMBOL_W-1:0] sym,
                           input logic [PIDX_W-1:0] pidx);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, pidx, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind != KIND_UNUSED) beats_sent++;
  endtask

  // drop valid and let every expected result drain before touching registers
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic sel, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // upper data bits are random: the block must keep only the register width
  task automatic program_registers(input int plen, input int kerr);
    wait_quiet();
    cfg_access(1'b1, REG_PATTERN_LENGTH, {26'($urandom()), 6'(plen)});
    cfg_access(1'b1, REG_MAX_MISMATCHES, {30'($urandom()), 2'(kerr)});
    cfg_access(1'b0, REG_PATTERN_LENGTH, $urandom());
    cfg_access(1'b0, REG_MAX_MISMATCHES, $urandom());
  endtask

  task automatic load_pattern(input int m, input int alph);
    send_beat(KIND_CLEAR, 8'($urandom()), 5'($urandom()));
    for (int i = 0; i < m; i++) begin
      pattern[i] = LETTER_FIRST + 8'($urandom_range(alph - 1, 0));
      send_beat(KIND_LOAD, pattern[i], 5'(i));
      // a second letter at the same position acts as a wildcard
      if ($urandom_range(9, 0) == 0)
        send_beat(KIND_LOAD, LETTER_FIRST + 8'($urandom_range(alph - 1, 0)), 5'(i));
    end
  endtask

  task automatic stream_text(input int n, input int m, input int kerr, input int alph);
    logic [SYMBOL_W-1:0] window [32];
    int                  sent;
    int                  r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        // embed the pattern with up to k+1 substitutions
        for (int i = 0; i < m; i++) window[i] = pattern[i];
        repeat ($urandom_range(kerr + 1, 0)) begin
          if ($urandom_range(9, 0) == 0)
            window[$urandom_range(m - 1, 0)] = 8'($urandom());
          else
            window[$urandom_range(m - 1, 0)] = LETTER_FIRST + 8'($urandom_range(25, 0));
        end
        for (int i = 0; i < m; i++) send_beat(KIND_TEXT, window[i], 5'($urandom()));
        sent += m;
      end else if (r < 85) begin
        send_beat(KIND_TEXT, LETTER_FIRST + 8'($urandom_range(alph - 1, 0)), 5'($urandom()));
        sent++;
      end else if (r < 95) begin
        send_beat(KIND_TEXT, 8'($urandom()), 5'($urandom()));
        sent++;
      end else if (r < 98) begin
        send_beat(KIND_UNUSED, 8'($urandom()), 5'($urandom()));
      end else begin
        send_beat(KIND_LOAD, LETTER_FIRST + 8'($urandom_range(25, 0)), 5'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    int plen;
    int kerr;
    int m;
    int alph;
    int phase;
    int sel;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= KIND_CLEAR;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    for (int i = 0; i < 32; i++) pattern[i] = LETTER_FIRST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, empty table, letter bounds, unused kind, clear
    gap_pct   = 30;
    stall_pct = 30;
    cfg_access(1'b0, REG_PATTERN_LENGTH, '0);
    cfg_access(1'b0, REG_MAX_MISMATCHES, '0);
    send_beat(KIND_TEXT, LETTER_FIRST, 5'd0);
    send_beat(KIND_LOAD, LETTER_FIRST, 5'd0);
    send_beat(KIND_LOAD, LETTER_LAST, 5'd31);
    send_beat(KIND_LOAD, 8'h00, 5'd0);
    send_beat(KIND_LOAD, 8'hff, 5'd31);
    send_beat(KIND_LOAD, LETTER_FIRST - 8'd1, 5'd0);
    send_beat(KIND_LOAD, LETTER_LAST + 8'd1, 5'd0);
    send_beat(KIND_TEXT, LETTER_FIRST, 5'd31);
    send_beat(KIND_TEXT, LETTER_LAST, 5'd0);
    send_beat(KIND_TEXT, LETTER_FIRST - 8'd1, 5'd0);
    send_beat(KIND_TEXT, LETTER_LAST + 8'd1, 5'd0);
    send_beat(KIND_TEXT, 8'hff, 5'd0);
    send_beat(KIND_TEXT, 8'h00, 5'd0);
    send_beat(KIND_UNUSED, LETTER_FIRST, 5'd0);
    send_beat(KIND_TEXT, LETTER_FIRST, 5'd0);
    send_beat(KIND_CLEAR, 8'hff, 5'd31);
    send_beat(KIND_TEXT, LETTER_FIRST, 5'd0);
    // zero length and the largest k: a substitution alone matches
    program_registers(0, 3);
    send_beat(KIND_TEXT, LETTER_FIRST + 8'd1, 5'd0);
    send_beat(KIND_TEXT, 8'hff, 5'd31);
    // length above the maximum with a full-width pattern
    program_registers(63, 0);
    load_pattern(32, 2);
    stream_text(70, 32, 0, 2);

    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      if (beats_sent > ITEM_TARGET - 200) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        sel       = $urandom_range(2, 0);
        gap_pct   = (sel == 0) ? 0 : ((sel == 1) ? 15 : 40);
        sel       = $urandom_range(2, 0);
        stall_pct = (sel == 0) ? 0 : ((sel == 1) ? 15 : 40);
      end
      case ($urandom_range(11, 0))
        0:       plen = 0;
        1:       plen = 63;
        2:       plen = 32;
        3:       plen = 33;
        4:       plen = $urandom_range(31, 9);
        default: plen = $urandom_range(8, 1);
      endcase
      kerr = $urandom_range(3, 0);
      m    = (plen == 0) ? 1 : ((plen > 32) ? 32 : plen);
      alph = $urandom_range(4, 2);
      program_registers(plen, kerr);
      // some phases keep the old table and vectors across the register change
      if (phase == 0 || $urandom_range(3, 0) != 0) load_pattern(m, alph);
      stream_text($urandom_range(120, 60), m, kerr, alph);
      phase++;
    end

    wait_quiet();
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
